[rtl/core/hbp_pkg.sv]
`default_nettype none

package hbp_pkg;

    localparam int GSHARE_INDEX_MAX_DEF  = 12;
    localparam int BIMODAL_INDEX_MAX_DEF = 12;
    localparam int CHOOSER_INDEX_MAX_DEF = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GSHARE_BITS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HISTORY_BITS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIMODAL_BITS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHOOSER_BITS = 3'd4;

    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_HYBRID  = 2'd2;

    localparam logic [1:0] CTR_MAX        = 2'd3;
    localparam logic [1:0] CTR_MIN        = 2'd0;
    localparam logic [1:0] CTR_RESET      = 2'd2;
    localparam logic [1:0] CHOOSER_RESET  = 2'd1;

    localparam logic [3:0] RESET_GSHARE_BITS  = 4'd12;
    localparam logic [3:0] RESET_HISTORY_BITS = 4'd8;
    localparam logic [3:0] RESET_BIMODAL_BITS = 4'd12;
    localparam logic [3:0] RESET_CHOOSER_BITS = 4'd12;

    typedef logic [1:0] ctr_t;
    typedef logic [4:0] width_t;

    function automatic ctr_t train(input ctr_t c, input logic t);
        ctr_t r;
        if (t)
        begin
            r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        end
        else
        begin
            r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        end
        return r;
    endfunction

    // zero acts as one, anything above the table size acts as the table size
    function automatic width_t eff_width(input logic [3:0] v, input width_t wmax);
        width_t r;
        if (v == 4'd0)
        begin
            r = 5'd1;
        end
        else if ({1'b0, v} > wmax)
        begin
            r = wmax;
        end
        else
        begin
            r = {1'b0, v};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/hbp_ram.sv]
`default_nettype none

module hbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/hybrid_branch_predictor.sv]
// Pipeline: tables are read and stage 1 loads at accept; stage 1 trains, and the result register
// loads when stage 1 advances. Throughput: one item per cycle while out_ready holds and no
// clearing pass runs; the registered table read plus write forwarding of the previous update
// lets neighbors hit the same entry back to back. Reset: config registers take their reset
// values, history and totals clear at once; then a clearing pass writes all three tables
// with in_ready low. Config writes are taken during the clearing pass.
`default_nettype none

module hybrid_branch_predictor #(
    parameter int GSHARE_INDEX_MAX  = hbp_pkg::GSHARE_INDEX_MAX_DEF,
    parameter int BIMODAL_INDEX_MAX = hbp_pkg::BIMODAL_INDEX_MAX_DEF,
    parameter int CHOOSER_INDEX_MAX = hbp_pkg::CHOOSER_INDEX_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [31:0]                    branch_address,
    input  wire logic                           taken,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                predicted_taken,
    output logic                                mispredicted,
    output logic                                chose_gshare,
    output logic [31:0]                         prediction_total,
    output logic [31:0]                         misprediction_total,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import hbp_pkg::*;

    localparam int GW = GSHARE_INDEX_MAX;
    localparam int BW = BIMODAL_INDEX_MAX;
    localparam int KW = CHOOSER_INDEX_MAX;
    localparam int SW = (GW > BW) ? ((GW > KW) ? GW : KW) : ((BW > KW) ? BW : KW);

    // configuration
    logic [1:0] mode_reg;
    logic [3:0] gbits_reg;
    logic [3:0] hbits_reg;
    logic [3:0] bbits_reg;
    logic [3:0] kbits_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BIMODAL;
            gbits_reg <= RESET_GSHARE_BITS;
            hbits_reg <= RESET_HISTORY_BITS;
            bbits_reg <= RESET_BIMODAL_BITS;
            kbits_reg <= RESET_CHOOSER_BITS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE:         mode_reg  <= cfg_data[1:0];
                REG_GSHARE_BITS:  gbits_reg <= cfg_data;
                REG_HISTORY_BITS: hbits_reg <= cfg_data;
                REG_BIMODAL_BITS: bbits_reg <= cfg_data;
                REG_CHOOSER_BITS: kbits_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clearing pass
    logic          clearing_reg;
    logic [SW-1:0] clear_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_idx_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_idx_reg <= clear_idx_reg + 1'b1;
            if (clear_idx_reg == {SW{1'b1}})
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // index formation at accept
    logic [29:0]   pc;
    width_t        m1;
    width_t        m2;
    width_t        mk;
    width_t        nh;
    logic [GW-1:0] mask_m1;
    logic [GW-1:0] mask_n;
    logic [BW-1:0] mask_m2;
    logic [KW-1:0] mask_k;
    logic [GW-1:0] hist_reg;
    logic [GW-1:0] hist_next;
    logic [GW-1:0] hist_sh;
    logic [GW-1:0] gi;
    logic [BW-1:0] bi;
    logic [KW-1:0] ci;
    logic          accept;
    logic          s1_adv;
    logic          s1_valid_reg;

    assign pc = branch_address[31:2];
    assign m1 = eff_width(gbits_reg, width_t'(GW));
    assign m2 = eff_width(bbits_reg, width_t'(BW));
    assign mk = eff_width(kbits_reg, width_t'(KW));
    assign nh = ({1'b0, hbits_reg} < m1) ? {1'b0, hbits_reg} : m1;

    always_comb
    begin
        for (int i = 0; i < GW; i++)
        begin
            mask_m1[i] = (width_t'(i) < m1);
            mask_n[i]  = (width_t'(i) < nh);
        end
        for (int i = 0; i < BW; i++)
        begin
            mask_m2[i] = (width_t'(i) < m2);
        end
        for (int i = 0; i < KW; i++)
        begin
            mask_k[i] = (width_t'(i) < mk);
        end
    end

    assign hist_sh = (hist_reg & mask_n) << (m1 - nh);
    assign gi      = (hist_sh ^ pc[GW-1:0]) & mask_m1;
    assign bi      = pc[BW-1:0] & mask_m2;
    assign ci      = pc[KW-1:0] & mask_k;

    assign in_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    // the outcome is known on entry, so history moves at accept in gshare and hybrid modes
    always_comb
    begin
        hist_next = hist_reg;
        if (nh != 5'd0 && (mode_reg == MODE_GSHARE || mode_reg == MODE_HYBRID))
        begin
            hist_next = (hist_reg >> 1) | ({{(GW-1){1'b0}}, taken} << (nh - 5'd1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (accept)
        begin
            hist_reg <= hist_next;
        end
    end

    // stage 1: table data arrives
    logic          s1_taken_reg;
    logic [GW-1:0] s1_gi_reg;
    logic [BW-1:0] s1_bi_reg;
    logic [KW-1:0] s1_ci_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_taken_reg <= taken;
            s1_gi_reg    <= gi;
            s1_bi_reg    <= bi;
            s1_ci_reg    <= ci;
        end
    end

    // tables
    ctr_t          b_rdata;
    ctr_t          g_rdata;
    ctr_t          c_rdata;
    ctr_t          b_new;
    ctr_t          g_new;
    ctr_t          c_new;
    logic          ram_we;
    logic [BW-1:0] b_waddr;
    logic [GW-1:0] g_waddr;
    logic [KW-1:0] c_waddr;
    ctr_t          b_wdata;
    ctr_t          g_wdata;
    ctr_t          c_wdata;

    assign ram_we  = clearing_reg || s1_adv;
    assign b_waddr = clearing_reg ? clear_idx_reg[BW-1:0] : s1_bi_reg;
    assign g_waddr = clearing_reg ? clear_idx_reg[GW-1:0] : s1_gi_reg;
    assign c_waddr = clearing_reg ? clear_idx_reg[KW-1:0] : s1_ci_reg;
    assign b_wdata = clearing_reg ? CTR_RESET : b_new;
    assign g_wdata = clearing_reg ? CTR_RESET : g_new;
    assign c_wdata = clearing_reg ? CHOOSER_RESET : c_new;

    hbp_ram #(.WIDTH(2), .DEPTH(2 ** BW)) u_bimodal_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (accept),
        .raddr (bi),
        .rdata (b_rdata)
    );

    hbp_ram #(.WIDTH(2), .DEPTH(2 ** GW)) u_gshare_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (accept),
        .raddr (gi),
        .rdata (g_rdata)
    );

    hbp_ram #(.WIDTH(2), .DEPTH(2 ** KW)) u_chooser_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (accept),
        .raddr (ci),
        .rdata (c_rdata)
    );

    // Every item writes all three tables (unchanged entries write back their value),
    // so the last write is always the newest copy of its entry.
    logic          fwd_valid_reg;
    logic [BW-1:0] fwd_bi_reg;
    logic [GW-1:0] fwd_gi_reg;
    logic [KW-1:0] fwd_ci_reg;
    ctr_t          fwd_b_reg;
    ctr_t          fwd_g_reg;
    ctr_t          fwd_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            fwd_bi_reg <= s1_bi_reg;
            fwd_gi_reg <= s1_gi_reg;
            fwd_ci_reg <= s1_ci_reg;
            fwd_b_reg  <= b_new;
            fwd_g_reg  <= g_new;
            fwd_c_reg  <= c_new;
        end
    end

    ctr_t b_cur;
    ctr_t g_cur;
    ctr_t c_cur;
    logic bp;
    logic gp;
    logic chose;
    logic pred;
    logic t1;

    assign b_cur = (fwd_valid_reg && fwd_bi_reg == s1_bi_reg) ? fwd_b_reg : b_rdata;
    assign g_cur = (fwd_valid_reg && fwd_gi_reg == s1_gi_reg) ? fwd_g_reg : g_rdata;
    assign c_cur = (fwd_valid_reg && fwd_ci_reg == s1_ci_reg) ? fwd_c_reg : c_rdata;
    assign t1    = s1_taken_reg;
    assign bp    = b_cur[1];
    assign gp    = g_cur[1];

    always_comb
    begin
        b_new = b_cur;
        g_new = g_cur;
        c_new = c_cur;
        chose = 1'b0;
        case (mode_reg)
            MODE_GSHARE:
            begin
                pred  = gp;
                g_new = train(g_cur, t1);
            end
            MODE_HYBRID:
            begin
                chose = c_cur[1];
                pred  = chose ? gp : bp;
                if (chose)
                begin
                    g_new = train(g_cur, t1);
                end
                else
                begin
                    b_new = train(b_cur, t1);
                end
                if (gp == t1 && bp != t1)
                begin
                    c_new = train(c_cur, 1'b1);
                end
                else if (gp != t1 && bp == t1)
                begin
                    c_new = train(c_cur, 1'b0);
                end
            end
            default:
            begin
                pred  = bp;
                b_new = train(b_cur, t1);
            end
        endcase
    end

    // result register and running totals
    logic        out_valid_reg;
    logic        pred_reg;
    logic        miss_reg;
    logic        chose_reg;
    logic [31:0] pred_cnt_reg;
    logic [31:0] miss_cnt_reg;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pred_cnt_reg  <= '0;
            miss_cnt_reg  <= '0;
        end
        else
        begin
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                if (pred_cnt_reg != 32'hFFFF_FFFF)
                begin
                    pred_cnt_reg <= pred_cnt_reg + 32'd1;
                end
                if (pred != t1 && miss_cnt_reg != 32'hFFFF_FFFF)
                begin
                    miss_cnt_reg <= miss_cnt_reg + 32'd1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pred_reg  <= pred;
            miss_reg  <= (pred != t1);
            chose_reg <= chose;
        end
    end

    assign out_valid           = out_valid_reg;
    assign predicted_taken     = pred_reg;
    assign mispredicted        = miss_reg;
    assign chose_gshare        = chose_reg;
    assign prediction_total    = pred_cnt_reg;
    assign misprediction_total = miss_cnt_reg;

    // checks
    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg && !out_valid_reg)
        else $error("item in flight during clearing pass");

    a_miss_le_pred: assert property (@(posedge clk) disable iff (!rst_n)
        miss_cnt_reg <= pred_cnt_reg)
        else $error("misprediction total exceeds prediction total");

    a_pred_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (pred_cnt_reg == $past(pred_cnt_reg) + 32'd1)
                   || ($past(pred_cnt_reg) == 32'hFFFF_FFFF))
        else $error("prediction total did not advance with a result");

    a_chose_only_hybrid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && chose_reg |-> mode_reg == MODE_HYBRID)
        else $error("gshare choice reported outside hybrid mode");

    a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && miss_reg |-> miss_cnt_reg != 32'd0)
        else $error("misprediction shown but not counted");

endmodule

`default_nettype wire
